/* sv/dfr_pkg.sv */
// Package for the delimiter framer: payload types, register indexes, reset values.
package dfr_pkg;

    localparam int DEF_MAX_SEP_LEN = 8;
    localparam int DEF_OFFSET_BITS = 32;

    localparam int PATTERN_BITS   = 64;
    localparam int SEP_LEN_BITS   = 4;
    localparam int CFG_INDEX_BITS = 2;
    localparam int OUT_BITS       = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SEP_PATTERN = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SEP_LENGTH  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TRIM_SEP    = 2'd2;

    localparam logic [PATTERN_BITS-1:0] RST_SEP_PATTERN = 64'h0000_0000_0000_0D0A;
    localparam logic [SEP_LEN_BITS-1:0] RST_SEP_LENGTH  = 4'd2;
    localparam logic                    RST_TRIM_SEP    = 1'b0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } byte_payload_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] part_offset;
        logic [OUT_BITS-1:0] part_length;
    } part_payload_t;

    typedef struct packed {
        logic [PATTERN_BITS-1:0] sep_pattern;
        logic [SEP_LEN_BITS-1:0] sep_length;
        logic                    trim_sep;
    } cfg_t;

    typedef struct packed {
        logic          hit;
        part_payload_t part;
    } match_result_t;

endpackage

/* sv/dfr_stream_if.sv */
// Valid/ready channel interfaces for stream bytes and finished parts.
interface dfr_byte_if;
    logic                   valid;
    logic                   ready;
    dfr_pkg::byte_payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface dfr_part_if;
    logic                   valid;
    logic                   ready;
    dfr_pkg::part_payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* sv/dfr_core.sv */
// Framing state and separator matcher: advance one byte per step.
module dfr_core #(
    parameter int MAX_SEP_LEN = dfr_pkg::DEF_MAX_SEP_LEN,
    parameter int OFFSET_BITS = dfr_pkg::DEF_OFFSET_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  dfr_pkg::byte_payload_t item,
    input  dfr_pkg::cfg_t          cfg,
    output dfr_pkg::match_result_t result
);

    localparam int WIN_BITS = 8 * MAX_SEP_LEN;
    localparam int LEN_BITS = $clog2(MAX_SEP_LEN + 1);

    logic [WIN_BITS-1:0]    window_reg;
    logic [WIN_BITS-1:0]    window_next;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic [OFFSET_BITS-1:0] offset_next;
    logic [OFFSET_BITS-1:0] start_reg;
    logic [OFFSET_BITS-1:0] start_base;
    logic [LEN_BITS-1:0]    count_reg;
    logic [LEN_BITS-1:0]    count_next;
    logic [LEN_BITS-1:0]    eff_len;
    logic [OFFSET_BITS-1:0] part_len;
    logic                   mismatch;
    logic                   hit;

    // Clamp separator length into 1..MAX_SEP_LEN.
    always_comb
    begin
        if (cfg.sep_length == '0)
        begin
            eff_len = LEN_BITS'(1);
        end
        else if (cfg.sep_length > dfr_pkg::SEP_LEN_BITS'(MAX_SEP_LEN))
        begin
            eff_len = LEN_BITS'(MAX_SEP_LEN);
        end
        else
        begin
            eff_len = LEN_BITS'(cfg.sep_length);
        end
    end

    // Restart clears the stream before the byte is taken.
    always_comb
    begin
        logic [WIN_BITS-1:0]    window_base;
        logic [OFFSET_BITS-1:0] offset_base;
        logic [LEN_BITS-1:0]    count_base;
        window_base = item.restart ? '0 : window_reg;
        offset_base = item.restart ? '0 : offset_reg;
        start_base  = item.restart ? '0 : start_reg;
        count_base  = item.restart ? '0 : count_reg;
        window_next = (window_base << 8) | WIN_BITS'(item.data_byte);
        offset_next = offset_base + OFFSET_BITS'(1);
        count_next  = (count_base < LEN_BITS'(MAX_SEP_LEN)) ?
                      count_base + LEN_BITS'(1) : count_base;
    end

    always_comb
    begin
        mismatch = 1'b0;
        for (int i = 0; i < MAX_SEP_LEN; i++)
        begin
            if ((i < int'(eff_len)) &&
                (window_next[8*i +: 8] != cfg.sep_pattern[8*i +: 8]))
            begin
                mismatch = 1'b1;
            end
        end
    end

    assign hit = (count_next >= eff_len) && !mismatch;

    always_comb
    begin
        part_len = offset_next - start_base;
        if (cfg.trim_sep)
        begin
            part_len = part_len - OFFSET_BITS'(eff_len);
        end
    end

    assign result.hit              = hit;
    assign result.part.part_offset = dfr_pkg::OUT_BITS'(start_base);
    assign result.part.part_length = dfr_pkg::OUT_BITS'(part_len);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            offset_reg <= '0;
            start_reg  <= '0;
            count_reg  <= '0;
        end
        else if (step)
        begin
            window_reg <= window_next;
            offset_reg <= offset_next;
            start_reg  <= hit ? offset_next : start_base;
            count_reg  <= hit ? '0 : count_next;
        end
    end

endmodule

/* sv/delimiter_framer_top.sv */
// Top level of the delimiter framer: config registers, input stage, result register.
// A result reaches part_stream through the input stage and then the result register after its final byte is accepted.
// Throughput: one byte per cycle unless a held result stalls the output; dfr_core updates its state on each step.
// A result waiting in the output register stops the next byte from entering only when the input stage is full.
// Reset (rst_n low, asynchronous): stream state cleared, registers to CR LF, length 2,
// no trim; both pipeline stages empty.
module delimiter_framer_top #(
    parameter int MAX_SEP_LEN = dfr_pkg::DEF_MAX_SEP_LEN,
    parameter int OFFSET_BITS = dfr_pkg::DEF_OFFSET_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    dfr_byte_if.sink                           byte_stream,
    dfr_part_if.source                         part_stream,
    input  logic                               wr_en,
    input  logic [dfr_pkg::CFG_INDEX_BITS-1:0] wr_index,
    input  logic [dfr_pkg::PATTERN_BITS-1:0]   wr_data
);

    // Configuration registers; the user must write them only while the block is idle; the block does not enforce it.
    dfr_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sep_pattern <= dfr_pkg::RST_SEP_PATTERN;
            cfg_reg.sep_length  <= dfr_pkg::RST_SEP_LENGTH;
            cfg_reg.trim_sep    <= dfr_pkg::RST_TRIM_SEP;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                dfr_pkg::REG_SEP_PATTERN: cfg_reg.sep_pattern <= wr_data;
                dfr_pkg::REG_SEP_LENGTH:
                    cfg_reg.sep_length <= wr_data[dfr_pkg::SEP_LEN_BITS-1:0];
                dfr_pkg::REG_TRIM_SEP:    cfg_reg.trim_sep <= wr_data[0];
                default:                  ;  // unused index: drop the write
            endcase
        end
    end

    // Input stage: one byte held ahead of the framing logic.
    logic                   in_valid_reg;
    dfr_pkg::byte_payload_t in_data_reg;
    logic                   out_valid_reg;
    dfr_pkg::part_payload_t out_data_reg;
    logic                   advance;
    logic                   step;
    dfr_pkg::match_result_t result;

    // The result register can take a new value when empty or being drained.
    assign advance           = !out_valid_reg || part_stream.ready;
    assign step              = in_valid_reg && advance;
    assign byte_stream.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_stream.ready)
        begin
            in_valid_reg <= byte_stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_stream.ready && byte_stream.valid)
        begin
            in_data_reg <= byte_stream.payload;
        end
    end

    dfr_core #(
        .MAX_SEP_LEN (MAX_SEP_LEN),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_data_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    // Result register: load on a match, clear when taken with nothing behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step && result.hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && result.hit)
        begin
            out_data_reg <= result.part;
        end
    end

    assign part_stream.valid   = out_valid_reg;
    assign part_stream.payload = out_data_reg;

    // Input backs up only when both stages are full and the output is stalled.
    a_ready_only_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_stream.ready |-> (in_valid_reg && out_valid_reg && !part_stream.ready))
        else $error("input stalled without a full, blocked pipeline");

    // A match on a step always shows up as a pending result.
    a_hit_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        (step && result.hit) |=> out_valid_reg)
        else $error("matched part lost before the result register");

    // A part found on a restart byte starts at offset zero.
    a_restart_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (step && in_data_reg.restart && result.hit) |-> (result.part.part_offset == '0))
        else $error("part after restart does not start at zero");

    // A stalled result holds until taken.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !part_stream.ready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("pending result changed while stalled");

endmodule
